// ----- rtl/tlme_pkg.sv -----
// Shared types, constants and offset tables for the trimer lattice move unit.
`timescale 1ns / 1ps

package tlme_pkg;

  localparam int MAX_SIDE = 64;
  localparam int COORD_W  = $clog2(MAX_SIDE);
  localparam int SIZE_W   = COORD_W + 1;
  localparam int VADDR_W  = 2 * COORD_W;
  localparam int SADDR_W  = VADDR_W + 1;
  localparam int TOTAL_W  = 16;

  typedef enum logic [1:0] {
    CMD_PLACE  = 2'd0,
    CMD_EVAL   = 2'd1,
    CMD_COMMIT = 2'd2,
    CMD_NONE   = 2'd3
  } cmd_e;

  typedef enum logic [1:0] {
    STAT_OK        = 2'd0,
    STAT_RANGE     = 2'd1,
    STAT_SRC_EMPTY = 2'd2,
    STAT_DST_OCC   = 2'd3
  } status_e;

  typedef enum logic {
    CFG_WIDTH  = 1'b0,
    CFG_HEIGHT = 1'b1
  } cfg_idx_e;

  typedef enum logic [3:0] {
    S_CLEAR,
    S_IDLE,
    S_SRC_RD,
    S_SRC_EV,
    S_NBR,
    S_VTX,
    S_DST_RD,
    S_DST_EV,
    S_DST_SET,
    S_UNDO_DST,
    S_UNDO_SRC,
    S_UNDO_VTX,
    S_FIN
  } state_e;

  // Request to the shared address unit: base trimer and a signed offset.
  typedef struct packed {
    logic [COORD_W-1:0] x;
    logic [COORD_W-1:0] y;
    logic signed [2:0]  dx;
    logic signed [2:0]  dy;
    logic               sub;
  } addr_req_t;

  // Neighbor offsets, indexed by sublattice and neighbor number.
  function automatic logic signed [2:0] nbr_dx(input logic s, input logic [2:0] k);
    logic signed [2:0] r;
    r = 3'sd0;
    case ({s, k})
      4'b0_001: r = 3'sd1;
      4'b0_011: r = 3'sd1;
      4'b0_100: r = -3'sd2;
      4'b0_101: r = -3'sd2;
      4'b1_001: r = -3'sd1;
      4'b1_010: r = 3'sd2;
      4'b1_011: r = 3'sd2;
      4'b1_101: r = -3'sd1;
      default:  r = 3'sd0;
    endcase
    return r;
  endfunction

  function automatic logic signed [2:0] nbr_dy(input logic s, input logic [2:0] k);
    logic signed [2:0] r;
    r = 3'sd0;
    case ({s, k})
      4'b0_000: r = 3'sd1;
      4'b0_010: r = -3'sd2;
      4'b0_011: r = -3'sd2;
      4'b0_101: r = 3'sd1;
      4'b1_000: r = 3'sd2;
      4'b1_001: r = 3'sd2;
      4'b1_011: r = -3'sd1;
      4'b1_100: r = -3'sd1;
      default:  r = 3'sd0;
    endcase
    return r;
  endfunction

  // Covered vertex offsets and mask bits.
  function automatic logic signed [2:0] vtx_dx(input logic s, input logic [2:0] k);
    return (k == 3'd0 || (s && k == 3'd2)) ? 3'sd1 : 3'sd0;
  endfunction

  function automatic logic signed [2:0] vtx_dy(input logic s, input logic [2:0] k);
    return (k == 3'd1 || (s && k == 3'd2)) ? 3'sd1 : 3'sd0;
  endfunction

  function automatic logic [7:0] vtx_bit(input logic s, input logic [2:0] k);
    logic [7:0] r;
    case (k)
      3'd0:    r = s ? 8'h20 : 8'h10;
      3'd1:    r = s ? 8'h08 : 8'h04;
      default: r = s ? 8'h80 : 8'h01;
    endcase
    return r;
  endfunction

  function automatic logic [3:0] pop8(input logic [7:0] v);
    logic [3:0] n;
    n = 4'd0;
    for (int i = 0; i < 8; i++) begin
      n = n + {3'd0, v[i]};
    end
    return n;
  endfunction

endpackage

// ----- rtl/tlme_addr_unit.sv -----
// Shared address unit: applies a wrapped offset to a lattice coordinate pair.
`timescale 1ns / 1ps

module tlme_addr_unit
  import tlme_pkg::*;
(
  input  addr_req_t          req_i,
  input  logic [SIZE_W-1:0]  width_i,
  input  logic [SIZE_W-1:0]  height_i,
  output logic [VADDR_W-1:0] vtx_addr_o,
  output logic [SADDR_W-1:0] site_addr_o
);

  logic signed [SIZE_W+1:0] tx, ty;
  logic [COORD_W-1:0] vx, vy;

  // Periodic wrap: the offset is at most two, the size at least three.
  always_comb begin
    tx = signed'({3'b000, req_i.x}) + (SIZE_W+2)'(req_i.dx);
    ty = signed'({3'b000, req_i.y}) + (SIZE_W+2)'(req_i.dy);
    if (tx < 0) begin
      tx = tx + signed'({2'b00, width_i});
    end else if (tx >= signed'({2'b00, width_i})) begin
      tx = tx - signed'({2'b00, width_i});
    end
    if (ty < 0) begin
      ty = ty + signed'({2'b00, height_i});
    end else if (ty >= signed'({2'b00, height_i})) begin
      ty = ty - signed'({2'b00, height_i});
    end
    vx = tx[COORD_W-1:0];
    vy = ty[COORD_W-1:0];
  end

  assign vtx_addr_o  = {vy, vx};
  assign site_addr_o = {vy, vx, req_i.sub};

endmodule

// ----- rtl/tlme_lattice_mem.sv -----
// Site occupancy and vertex mask memories, one access each per cycle.
`timescale 1ns / 1ps

module tlme_lattice_mem
  import tlme_pkg::*;
(
  input  logic               clk_i,
  input  logic [SADDR_W-1:0] site_addr_i,
  input  logic               site_we_i,
  input  logic               site_wdata_i,
  output logic               site_rdata_o,
  input  logic [VADDR_W-1:0] vtx_addr_i,
  input  logic               vtx_we_i,
  input  logic [7:0]         vtx_wdata_i,
  output logic [7:0]         vtx_rdata_o
);

  logic       site_mem [2**SADDR_W];
  logic [7:0] vtx_mem  [2**VADDR_W];

  // Site bits, registered read.
  always_ff @(posedge clk_i) begin
    if (site_we_i) begin
      site_mem[site_addr_i] <= site_wdata_i;
    end
    site_rdata_o <= site_mem[site_addr_i];
  end

  // Vertex masks, registered read.
  always_ff @(posedge clk_i) begin
    if (vtx_we_i) begin
      vtx_mem[vtx_addr_i] <= vtx_wdata_i;
    end
    vtx_rdata_o <= vtx_mem[vtx_addr_i];
  end

endmodule

// ----- rtl/trimer_lattice_move_energy_top.sv -----
// Top level of the trimer lattice move unit: sequencer, totals and ports.
`timescale 1ns / 1ps

// Usage:
// One input item carries a command and source and destination trimers; each
// item yields exactly one result item on the output channel. Both channels
// use valid/ready. The lattice size registers are written through the plain
// write port; the user must write them only while the block is idle, as the
// block itself does not enforce it; sizes are clamped to 3..64. The order of
// work is set by the single shared address unit and the single port of each
// lattice memory: every neighbor bit and vertex mask is read in its own step
// of an address phase and a read phase, and evaluate rolls back with one
// memory write per cycle. One item is in work at a time; in_ready_o is low
// while it runs. After reset a clearing pass empties the lattice memories;
// no item is accepted until it ends. Configuration writes are taken always.
// A result waits in the output register while the receiver stalls; a new
// item is accepted only once that register is free or being emptied.

module trimer_lattice_move_energy_top
  import tlme_pkg::*;
(
  input  logic                      clk_i,
  input  logic                      rst_ni,
  input  logic                      cfg_we_i,
  input  logic                      cfg_index_i,
  input  logic [SIZE_W-1:0]         cfg_wdata_i,
  input  logic                      in_valid_i,
  output logic                      in_ready_o,
  input  logic [1:0]                command_i,
  input  logic [COORD_W-1:0]        source_x_i,
  input  logic [COORD_W-1:0]        source_y_i,
  input  logic                      source_sub_i,
  input  logic [COORD_W-1:0]        dest_x_i,
  input  logic [COORD_W-1:0]        dest_y_i,
  input  logic                      dest_sub_i,
  output logic                      out_valid_o,
  input  logic                      out_ready_i,
  output logic [1:0]                status_o,
  output logic signed [3:0]         delta_pairs_o,
  output logic signed [5:0]         delta_clusters_o,
  output logic [TOTAL_W-1:0]        pair_total_o,
  output logic [TOTAL_W-1:0]        cluster_total_o
);

  state_e st_q, st_d;

  logic [SIZE_W-1:0]  width_q, height_q, w_eff, h_eff;
  logic [SADDR_W-1:0] clr_cnt_q;
  logic [2:0]         k_q;
  logic               ph_q, dst_q;
  cmd_e               cmd_q;
  logic [COORD_W-1:0] sx_q, sy_q, tx_q, ty_q;
  logic               ss_q, ts_q;
  status_e            status_q;
  logic signed [3:0]  dp_q;
  logic signed [5:0]  dc_q;
  logic [TOTAL_W-1:0] pair_q, clus_q;
  logic [VADDR_W-1:0] va_q  [6];
  logic [7:0]         old_q [6];
  logic               ovalid_q;
  logic [1:0]         ostat_q;
  logic signed [3:0]  odp_q;
  logic signed [5:0]  odc_q;

  logic               in_fire, bad_src, bad_dst, cur_sub;
  addr_req_t          req;
  logic [VADDR_W-1:0] u_vaddr;
  logic [SADDR_W-1:0] u_saddr;
  logic [SADDR_W-1:0] site_addr;
  logic               site_we, site_wd, site_rd;
  logic [VADDR_W-1:0] vtx_addr;
  logic               vtx_we;
  logic [7:0]         vtx_wd, vtx_rd, vbit;
  logic [3:0]         vpop;
  logic [2:0]         vidx;
  logic signed [17:0] psum, csum;
  logic [TOTAL_W-1:0] pair_sat, clus_sat;

  // Clamp the size registers to the supported range.
  always_comb begin
    w_eff = (width_q < SIZE_W'(3)) ? SIZE_W'(3) :
            (width_q > SIZE_W'(MAX_SIDE)) ? SIZE_W'(MAX_SIDE) : width_q;
    h_eff = (height_q < SIZE_W'(3)) ? SIZE_W'(3) :
            (height_q > SIZE_W'(MAX_SIDE)) ? SIZE_W'(MAX_SIDE) : height_q;
  end

  assign in_ready_o = (st_q == S_IDLE) && (!ovalid_q || out_ready_i);
  assign in_fire    = in_valid_i && in_ready_o;
  assign bad_dst    = ({1'b0, dest_x_i} >= w_eff) || ({1'b0, dest_y_i} >= h_eff);
  assign bad_src    = ({1'b0, source_x_i} >= w_eff) || ({1'b0, source_y_i} >= h_eff);

  // Feed the shared address unit from the trimer in work.
  assign cur_sub = dst_q ? ts_q : ss_q;
  always_comb begin
    req.x   = dst_q ? tx_q : sx_q;
    req.y   = dst_q ? ty_q : sy_q;
    req.sub = ~cur_sub;
    if (st_q == S_NBR) begin
      req.dx = nbr_dx(cur_sub, k_q);
      req.dy = nbr_dy(cur_sub, k_q);
    end else begin
      req.dx = vtx_dx(cur_sub, k_q);
      req.dy = vtx_dy(cur_sub, k_q);
    end
  end

  tlme_addr_unit u_addr (
    .req_i       (req),
    .width_i     (w_eff),
    .height_i    (h_eff),
    .vtx_addr_o  (u_vaddr),
    .site_addr_o (u_saddr)
  );

  tlme_lattice_mem u_mem (
    .clk_i        (clk_i),
    .site_addr_i  (site_addr),
    .site_we_i    (site_we),
    .site_wdata_i (site_wd),
    .site_rdata_o (site_rd),
    .vtx_addr_i   (vtx_addr),
    .vtx_we_i     (vtx_we),
    .vtx_wdata_i  (vtx_wd),
    .vtx_rdata_o  (vtx_rd)
  );

  assign vbit = vtx_bit(cur_sub, k_q);
  assign vpop = pop8(vtx_rd);
  assign vidx = dst_q ? (k_q + 3'd3) : k_q;

  // Next state.
  always_comb begin
    st_d = st_q;
    unique case (st_q)
      S_CLEAR:    if (&clr_cnt_q) st_d = S_IDLE;
      S_IDLE: begin
        if (in_fire) begin
          unique case (cmd_e'(command_i)) inside
            CMD_PLACE:             st_d = bad_dst ? S_FIN : S_DST_RD;
            CMD_EVAL, CMD_COMMIT:  st_d = (bad_src || bad_dst) ? S_FIN : S_SRC_RD;
            default:               st_d = S_FIN;
          endcase
        end
      end
      S_SRC_RD:   st_d = S_SRC_EV;
      S_SRC_EV:   st_d = site_rd ? S_NBR : S_FIN;
      S_NBR:      if (ph_q && k_q == 3'd5) st_d = S_VTX;
      S_VTX:      if (ph_q && k_q == 3'd2) st_d = dst_q ? S_DST_SET : S_DST_RD;
      S_DST_RD:   st_d = S_DST_EV;
      S_DST_EV: begin
        if (site_rd) begin
          st_d = (cmd_q == CMD_PLACE) ? S_FIN : S_UNDO_SRC;
        end else begin
          st_d = S_NBR;
        end
      end
      S_DST_SET:  st_d = (cmd_q == CMD_EVAL) ? S_UNDO_DST : S_FIN;
      S_UNDO_DST: st_d = S_UNDO_SRC;
      S_UNDO_SRC: st_d = S_UNDO_VTX;
      S_UNDO_VTX: if (k_q == 3'd0) st_d = S_FIN;
      S_FIN:      st_d = S_IDLE;
      default:    st_d = S_IDLE;
    endcase
  end

  // Memory port controls.
  always_comb begin
    site_addr = u_saddr;
    site_we   = 1'b0;
    site_wd   = 1'b0;
    vtx_addr  = u_vaddr;
    vtx_we    = 1'b0;
    vtx_wd    = dst_q ? (vtx_rd | vbit) : (vtx_rd & ~vbit);
    unique case (st_q) inside
      S_CLEAR: begin
        site_addr = clr_cnt_q;
        site_we   = 1'b1;
        vtx_addr  = clr_cnt_q[VADDR_W-1:0];
        vtx_we    = 1'b1;
        vtx_wd    = 8'h00;
      end
      S_SRC_RD:   site_addr = {sy_q, sx_q, ss_q};
      S_SRC_EV: begin
        site_addr = {sy_q, sx_q, ss_q};
        site_we   = site_rd;
      end
      S_DST_RD, S_DST_EV: site_addr = {ty_q, tx_q, ts_q};
      S_DST_SET: begin
        site_addr = {ty_q, tx_q, ts_q};
        site_we   = 1'b1;
        site_wd   = 1'b1;
      end
      S_UNDO_DST: begin
        site_addr = {ty_q, tx_q, ts_q};
        site_we   = 1'b1;
      end
      S_UNDO_SRC: begin
        site_addr = {sy_q, sx_q, ss_q};
        site_we   = 1'b1;
        site_wd   = 1'b1;
      end
      S_VTX:      vtx_we = ph_q;
      S_UNDO_VTX: begin
        vtx_addr = va_q[k_q];
        vtx_we   = 1'b1;
        vtx_wd   = old_q[k_q];
      end
      default: ;
    endcase
  end

  // Saturating total updates.
  always_comb begin
    psum = signed'({2'b00, pair_q}) + 18'(dp_q);
    csum = signed'({2'b00, clus_q}) + 18'(dc_q);
    pair_sat = (psum < 0) ? '0 : (psum > 18'sd65535) ? '1 : psum[TOTAL_W-1:0];
    clus_sat = (csum < 0) ? '0 : (csum > 18'sd65535) ? '1 : csum[TOTAL_W-1:0];
  end

  // Control registers.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      st_q      <= S_CLEAR;
      clr_cnt_q <= '0;
      width_q   <= SIZE_W'(48);
      height_q  <= SIZE_W'(48);
      pair_q    <= '0;
      clus_q    <= '0;
      ovalid_q  <= 1'b0;
      k_q       <= '0;
      ph_q      <= 1'b0;
      dst_q     <= 1'b0;
    end else begin
      st_q <= st_d;
      if (st_q == S_CLEAR) clr_cnt_q <= clr_cnt_q + SADDR_W'(1);
      if (cfg_we_i) begin
        if (cfg_idx_e'(cfg_index_i) == CFG_WIDTH) width_q <= cfg_wdata_i;
        else height_q <= cfg_wdata_i;
      end
      if (out_valid_o && out_ready_i) ovalid_q <= 1'b0;
      case (st_q)
        S_IDLE: begin
          if (in_fire) begin
            dst_q <= (cmd_e'(command_i) == CMD_PLACE);
            k_q   <= '0;
            ph_q  <= 1'b0;
          end
        end
        S_NBR: begin
          ph_q <= ~ph_q;
          if (ph_q) k_q <= (k_q == 3'd5) ? 3'd0 : k_q + 3'd1;
        end
        S_VTX: begin
          ph_q <= ~ph_q;
          if (ph_q) begin
            if (k_q == 3'd2) begin
              k_q <= 3'd0;
              if (!dst_q) dst_q <= 1'b1;
            end else begin
              k_q <= k_q + 3'd1;
            end
          end
        end
        S_DST_EV:   k_q <= site_rd ? 3'd2 : 3'd0;
        S_DST_SET:  k_q <= 3'd5;
        S_UNDO_VTX: k_q <= k_q - 3'd1;
        S_FIN: begin
          ovalid_q <= 1'b1;
          if (status_q == STAT_OK && (cmd_q == CMD_PLACE || cmd_q == CMD_COMMIT)) begin
            pair_q <= pair_sat;
            clus_q <= clus_sat;
          end
        end
        default: ;
      endcase
    end
  end

  // Item payload, deltas and rollback records.
  always_ff @(posedge clk_i) begin
    case (st_q)
      S_IDLE: begin
        if (in_fire) begin
          cmd_q    <= cmd_e'(command_i);
          sx_q     <= source_x_i;
          sy_q     <= source_y_i;
          ss_q     <= source_sub_i;
          tx_q     <= dest_x_i;
          ty_q     <= dest_y_i;
          ts_q     <= dest_sub_i;
          dp_q     <= '0;
          dc_q     <= '0;
          unique case (cmd_e'(command_i)) inside
            CMD_PLACE:            status_q <= bad_dst ? STAT_RANGE : STAT_OK;
            CMD_EVAL, CMD_COMMIT: status_q <= (bad_src || bad_dst) ? STAT_RANGE : STAT_OK;
            default:              status_q <= STAT_OK;
          endcase
        end
      end
      S_SRC_EV: if (!site_rd) status_q <= STAT_SRC_EMPTY;
      S_NBR: begin
        if (ph_q && site_rd) dp_q <= dst_q ? dp_q + 4'sd1 : dp_q - 4'sd1;
      end
      S_VTX: begin
        if (ph_q) begin
          va_q[vidx]  <= u_vaddr;
          old_q[vidx] <= vtx_rd;
          dc_q <= dst_q ? dc_q + signed'({2'b00, vpop})
                        : dc_q + 6'sd1 - signed'({2'b00, vpop});
        end
      end
      S_DST_EV: begin
        if (site_rd) begin
          status_q <= STAT_DST_OCC;
          dp_q     <= '0;
          dc_q     <= '0;
        end
      end
      S_FIN: begin
        ostat_q <= status_q;
        odp_q   <= dp_q;
        odc_q   <= dc_q;
      end
      default: ;
    endcase
  end

  assign out_valid_o      = ovalid_q;
  assign status_o         = ostat_q;
  assign delta_pairs_o    = odp_q;
  assign delta_clusters_o = odc_q;
  assign pair_total_o     = pair_q;
  assign cluster_total_o  = clus_q;

endmodule

// ----- dv/tlme_checker.sv -----
// Checker for the trimer lattice move unit: lattice predictor and result scoreboard.
`timescale 1ns / 1ps

module tlme_checker
  import tlme_pkg::*;
(
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 cfg_we_i,
  input  logic                 cfg_index_i,
  input  logic [SIZE_W-1:0]    cfg_wdata_i,
  input  logic                 in_valid_i,
  input  logic                 in_ready_o,
  input  logic [1:0]           command_i,
  input  logic [COORD_W-1:0]   source_x_i,
  input  logic [COORD_W-1:0]   source_y_i,
  input  logic                 source_sub_i,
  input  logic [COORD_W-1:0]   dest_x_i,
  input  logic [COORD_W-1:0]   dest_y_i,
  input  logic                 dest_sub_i,
  input  logic                 out_valid_o,
  input  logic                 out_ready_i,
  input  logic [1:0]           status_o,
  input  logic [3:0]           delta_pairs_o,
  input  logic [5:0]           delta_clusters_o,
  input  logic [TOTAL_W-1:0]   pair_total_o,
  input  logic [TOTAL_W-1:0]   cluster_total_o,
  output int                   fail_count,
  output int                   pending_count
);

  typedef struct packed {
    logic [1:0]  status;
    logic [3:0]  dpairs;
    logic [5:0]  dclusters;
    logic [15:0] ptotal;
    logic [15:0] ctotal;
  } move_result_t;

  // Lattice shadow state.
  bit       occ [MAX_SIDE*MAX_SIDE*2];
  bit [7:0] vmask [MAX_SIDE*MAX_SIDE];
  int       pairs_sum, overlap_sum;
  bit [6:0] width_reg, height_reg;
  move_result_t expected_q[$];

  function automatic int clamp_side(bit [6:0] r);
    if (r < 3) return 3;
    if (r > MAX_SIDE) return MAX_SIDE;
    return r;
  endfunction

  function automatic int wrapc(int c, int d, int n);
    return (c + d + n) % n;
  endfunction

  function automatic int sidx(int x, int y, int s);
    return (y * MAX_SIDE + x) * 2 + s;
  endfunction

  function automatic int occupied_nbrs(int x, int y, int s, int w, int h);
    int n;
    n = 0;
    for (int k = 0; k < 6; k++) begin
      int ox, oy;
      if (s == 0) begin
        case (k)
          0: begin ox = 0;  oy = 1;  end
          1: begin ox = 1;  oy = 0;  end
          2: begin ox = 0;  oy = -2; end
          3: begin ox = 1;  oy = -2; end
          4: begin ox = -2; oy = 0;  end
          default: begin ox = -2; oy = 1; end
        endcase
      end else begin
        case (k)
          0: begin ox = 0;  oy = 2;  end
          1: begin ox = -1; oy = 2;  end
          2: begin ox = 2;  oy = 0;  end
          3: begin ox = 2;  oy = -1; end
          4: begin ox = 0;  oy = -1; end
          default: begin ox = -1; oy = 0; end
        endcase
      end
      if (occ[sidx(wrapc(x, ox, w), wrapc(y, oy, h), 1 - s)]) n++;
    end
    return n;
  endfunction

  // Vertex index and mask bit of covered vertex k.
  function automatic int vaddr(int x, int y, int s, int k, int w, int h);
    int ox, oy;
    ox = (k == 0 || (s == 1 && k == 2)) ? 1 : 0;
    oy = (k == 1 || (s == 1 && k == 2)) ? 1 : 0;
    return wrapc(y, oy, h) * MAX_SIDE + wrapc(x, ox, w);
  endfunction

  function automatic bit [7:0] vbit(int s, int k);
    case (k)
      0: return s ? 8'h20 : 8'h10;
      1: return s ? 8'h08 : 8'h04;
      default: return s ? 8'h80 : 8'h01;
    endcase
  endfunction

  function automatic int sat16(int t, int d);
    int r;
    r = t + d;
    if (r < 0) return 0;
    if (r > 65535) return 65535;
    return r;
  endfunction

  // Applies one move to the shadow lattice and returns its result.
  function automatic move_result_t predict_move(cmd_e cmd, int sx, int sy, int ss,
                                                int tx, int ty, int ts);
    move_result_t r;
    int w, h, dp, dc, va;
    bit [7:0] saved [6];
    int addrs [6];
    status_e st;
    w = clamp_side(width_reg);
    h = clamp_side(height_reg);
    dp = 0;
    dc = 0;
    st = STAT_OK;
    if (cmd == CMD_PLACE) begin
      if (tx >= w || ty >= h) st = STAT_RANGE;
      else if (occ[sidx(tx, ty, ts)]) st = STAT_DST_OCC;
      else begin
        dp = occupied_nbrs(tx, ty, ts, w, h);
        for (int k = 0; k < 3; k++) begin
          va = vaddr(tx, ty, ts, k, w, h);
          dc += $countones(vmask[va]);
          vmask[va] |= vbit(ts, k);
        end
        occ[sidx(tx, ty, ts)] = 1;
        pairs_sum = sat16(pairs_sum, dp);
        overlap_sum = sat16(overlap_sum, dc);
      end
    end else if (cmd == CMD_EVAL || cmd == CMD_COMMIT) begin
      if (sx >= w || sy >= h || tx >= w || ty >= h) st = STAT_RANGE;
      else if (!occ[sidx(sx, sy, ss)]) st = STAT_SRC_EMPTY;
      else begin
        occ[sidx(sx, sy, ss)] = 0;
        dp -= occupied_nbrs(sx, sy, ss, w, h);
        for (int k = 0; k < 3; k++) begin
          va = vaddr(sx, sy, ss, k, w, h);
          addrs[k] = va;
          saved[k] = vmask[va];
          dc += 1 - $countones(vmask[va]);
          vmask[va] &= ~vbit(ss, k);
        end
        if (occ[sidx(tx, ty, ts)]) begin
          st = STAT_DST_OCC;
          for (int k = 2; k >= 0; k--) vmask[addrs[k]] = saved[k];
          occ[sidx(sx, sy, ss)] = 1;
          dp = 0;
          dc = 0;
        end else begin
          dp += occupied_nbrs(tx, ty, ts, w, h);
          for (int k = 0; k < 3; k++) begin
            va = vaddr(tx, ty, ts, k, w, h);
            addrs[3+k] = va;
            saved[3+k] = vmask[va];
            dc += $countones(vmask[va]);
            vmask[va] |= vbit(ts, k);
          end
          if (cmd == CMD_EVAL) begin
            // Roll back in reverse order so that shared vertices restore right.
            occ[sidx(sx, sy, ss)] = 1;
            for (int k = 5; k >= 0; k--) vmask[addrs[k]] = saved[k];
          end else begin
            occ[sidx(tx, ty, ts)] = 1;
            pairs_sum = sat16(pairs_sum, dp);
            overlap_sum = sat16(overlap_sum, dc);
          end
        end
      end
    end
    r.status = st;
    r.dpairs = dp[3:0];
    r.dclusters = dc[5:0];
    r.ptotal = pairs_sum[15:0];
    r.ctotal = overlap_sum[15:0];
    return r;
  endfunction

  task automatic report_mismatch(string what, int got, int want);
    $display("[%0t] mismatch on %s: got %0d, expected %0d", $realtime, what, got, want);
    fail_count++;
  endtask

  // Watch both channels and the configuration port at each rising edge.
  always @(posedge clk_i or negedge rst_ni) begin
    move_result_t e;
    if (!rst_ni) begin
      foreach (occ[i]) occ[i] = 0;
      foreach (vmask[i]) vmask[i] = 0;
      pairs_sum = 0;
      overlap_sum = 0;
      width_reg = 48;
      height_reg = 48;
      fail_count = 0;
      expected_q.delete();
      pending_count = 0;
    end else begin
      if (out_valid_o && out_ready_i) begin
        if (expected_q.size() == 0) begin
          report_mismatch("result item count", 1, 0);
        end else begin
          e = expected_q.pop_front();
          if (status_o !== e.status) report_mismatch("status", status_o, e.status);
          if (delta_pairs_o !== e.dpairs)
            report_mismatch("delta_pairs", delta_pairs_o, e.dpairs);
          if (delta_clusters_o !== e.dclusters)
            report_mismatch("delta_clusters", delta_clusters_o, e.dclusters);
          if (pair_total_o !== e.ptotal) report_mismatch("pair_total", pair_total_o, e.ptotal);
          if (cluster_total_o !== e.ctotal)
            report_mismatch("cluster_total", cluster_total_o, e.ctotal);
        end
      end
      if (in_valid_i && in_ready_o) begin
        expected_q.insert(expected_q.size(),
                          predict_move(cmd_e'(command_i), source_x_i, source_y_i,
                                       source_sub_i, dest_x_i, dest_y_i, dest_sub_i));
      end
      if (cfg_we_i) begin
        if (cfg_index_i == CFG_WIDTH) width_reg = cfg_wdata_i;
        else height_reg = cfg_wdata_i;
      end
      pending_count = expected_q.size();
    end
  end

endmodule

// ----- dv/tb.sv -----
// Testbench top for the trimer lattice move unit: stimulus, sizes and verdict.
`timescale 1ns / 1ps

module tb
  import tlme_pkg::*;
;

  logic                clk_i = 1'b0;
  logic                rst_ni = 1'b0;
  logic                cfg_we_i = 1'b0;
  logic                cfg_index_i = 1'b0;
  logic [SIZE_W-1:0]   cfg_wdata_i = '0;
  logic                in_valid_i = 1'b0;
  logic                in_ready_o;
  logic [1:0]          command_i = '0;
  logic [COORD_W-1:0]  source_x_i = '0, source_y_i = '0, dest_x_i = '0, dest_y_i = '0;
  logic                source_sub_i = 1'b0, dest_sub_i = 1'b0;
  logic                out_valid_o;
  logic                out_ready_i = 1'b0;
  logic [1:0]          status_o;
  logic signed [3:0]   delta_pairs_o;
  logic signed [5:0]   delta_clusters_o;
  logic [TOTAL_W-1:0]  pair_total_o, cluster_total_o;
  int                  fail_count, pending_count;
  bit                  stim_done = 0;
  int                  cur_w = 48, cur_h = 48;

  always #5 clk_i = ~clk_i;

  trimer_lattice_move_energy_top i_dut (.*);
  tlme_checker i_checker (.*);

  // Receiver stalls a random number of cycles before each result.
  initial begin
    int gap;
    @(posedge rst_ni);
    forever begin
      gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(0, 6);
      if (gap > 0) begin
        out_ready_i <= 1'b0;
        repeat (gap) @(negedge clk_i);
      end
      out_ready_i <= 1'b1;
      @(posedge clk_i);
      while (!out_valid_o) @(posedge clk_i);
      @(negedge clk_i);
    end
  end

  // Valid stays high after acceptance only until the next call changes it;
  // the block is busy after each accepted item until it returns to idle.
  task automatic send_move(cmd_e cmd, int sx, int sy, int ss, int tx, int ty, int ts);
    int gap;
    gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(0, 6);
    if (gap > 0) begin
      in_valid_i <= 1'b0;
      repeat (gap) @(negedge clk_i);
    end
    in_valid_i <= 1'b1;
    command_i <= cmd;
    source_x_i <= COORD_W'(sx);
    source_y_i <= COORD_W'(sy);
    source_sub_i <= 1'(ss);
    dest_x_i <= COORD_W'(tx);
    dest_y_i <= COORD_W'(ty);
    dest_sub_i <= 1'(ts);
    @(posedge clk_i);
    while (!in_ready_o) @(posedge clk_i);
    @(negedge clk_i);
  endtask

  // Waits until all results are in, then lets the block settle before a write.
  task automatic set_size(int w, int h);
    in_valid_i <= 1'b0;
    while (pending_count != 0) @(negedge clk_i);
    repeat (60) @(negedge clk_i);
    cfg_we_i <= 1'b1;
    cfg_index_i <= CFG_WIDTH;
    cfg_wdata_i <= SIZE_W'(w);
    @(negedge clk_i);
    cfg_index_i <= CFG_HEIGHT;
    cfg_wdata_i <= SIZE_W'(h);
    @(negedge clk_i);
    cfg_we_i <= 1'b0;
    cur_w = (w < 3) ? 3 : (w > 64) ? 64 : w;
    cur_h = (h < 3) ? 3 : (h > 64) ? 64 : h;
  endtask

  // Mostly in-range coordinates, now and then anything the field allows.
  function automatic int pick_coord(int n);
    return ($urandom_range(0, 9) == 0) ? $urandom_range(0, 63) : $urandom_range(0, n - 1);
  endfunction

  task automatic random_phase(int count);
    int c;
    for (int i = 0; i < count; i++) begin
      c = $urandom_range(0, 9);
      send_move(c < 4 ? CMD_PLACE : c < 6 ? CMD_EVAL : c < 9 ? CMD_COMMIT : CMD_NONE,
                pick_coord(cur_w), pick_coord(cur_h), $urandom_range(0, 1),
                pick_coord(cur_w), pick_coord(cur_h), $urandom_range(0, 1));
    end
  endtask

  initial begin
    repeat (12) @(negedge clk_i);
    rst_ni <= 1'b1;
    // Directed items on the reset size: range, empty source, occupied target,
    // self move, neighbors and shared vertices, unused command.
    send_move(CMD_PLACE, 0, 0, 0, 63, 0, 0);
    send_move(CMD_PLACE, 0, 0, 0, 0, 63, 1);
    send_move(CMD_EVAL, 5, 5, 0, 6, 6, 0);
    send_move(CMD_PLACE, 0, 0, 0, 10, 10, 0);
    send_move(CMD_PLACE, 0, 0, 0, 10, 10, 0);
    send_move(CMD_PLACE, 0, 0, 0, 10, 11, 1);
    send_move(CMD_PLACE, 0, 0, 0, 11, 10, 1);
    send_move(CMD_PLACE, 0, 0, 0, 9, 9, 1);
    send_move(CMD_PLACE, 0, 0, 0, 0, 0, 0);
    send_move(CMD_PLACE, 0, 0, 0, 47, 47, 1);
    send_move(CMD_EVAL, 10, 10, 0, 10, 10, 0);
    send_move(CMD_COMMIT, 10, 10, 0, 10, 11, 1);
    send_move(CMD_COMMIT, 10, 10, 0, 12, 12, 0);
    send_move(CMD_EVAL, 63, 63, 1, 1, 1, 0);
    send_move(CMD_COMMIT, 0, 0, 0, 63, 63, 1);
    send_move(CMD_COMMIT, 47, 47, 1, 0, 0, 1);
    send_move(CMD_NONE, 63, 63, 1, 63, 63, 1);
    send_move(CMD_EVAL, 10, 11, 1, 42, 21, 1);
    random_phase(60);
    // Small lattices crowd quickly and wrap hard; extremes of the size range.
    set_size(0, 127);
    random_phase(70);
    set_size(3, 3);
    random_phase(50);
    set_size(64, 5);
    random_phase(70);
    set_size(7, 64);
    random_phase(70);
    set_size(8, 8);
    random_phase(112);
    in_valid_i <= 1'b0;
    stim_done = 1;
  end

  initial begin
    wait (stim_done);
    while (pending_count != 0) @(negedge clk_i);
    repeat (100) @(negedge clk_i);
    if (fail_count == 0) $display("Regression PASS");
    else $display("Regression FAIL");
    $finish;
  end

  initial begin
    #5ms;
    $display("Regression FAIL");
    $finish;
  end

endmodule
